FILE: hdl/utf8_to_cp437_transcoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 to CP437 transcoder assertion macros
// Concurrent assertion wrappers used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CP437_TRANSCODER_MACROS_SVH
`define UTF8_TO_CP437_TRANSCODER_MACROS_SVH

// check a property on every rising edge outside reset
`define U2C_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising edge, reset included
`define U2C_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/u2c_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to CP437 package
// Shared types, constants and the code point to CP437 glyph table.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam logic [7:0]  UNMAPPED    = 8'h3F;
  localparam logic [7:0]  END_OF_TEXT = 8'h00;
  localparam logic [15:0] ASCII_MAX   = 16'h007F;
  localparam logic [2:0]  LEAD2_TAG   = 3'b110;
  localparam logic [3:0]  LEAD3_TAG   = 4'b1110;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ONE  = 2'd1,
    PEND_TWO  = 2'd2
  } pend_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] glyph;
  } dec_res_t;

  function automatic logic [7:0] map_point(input logic [15:0] pt);
    logic [7:0] g;
    if (pt <= ASCII_MAX) begin
      g = pt[7:0];
    end else begin
      case (pt)
        16'h00A0: g = 8'hFF;  16'h00A1: g = 8'hAD;  16'h00A2: g = 8'h9B;
        16'h00A3: g = 8'h9C;  16'h00A5: g = 8'h9D;  16'h00AA: g = 8'hA6;
        16'h00AB: g = 8'hAE;  16'h00AC: g = 8'hAA;  16'h00B0: g = 8'hF8;
        16'h00B1: g = 8'hF1;  16'h00B2: g = 8'hFD;  16'h00B5: g = 8'hE6;
        16'h00B7: g = 8'hFA;  16'h00BA: g = 8'hA7;  16'h00BB: g = 8'hAF;
        16'h00BC: g = 8'hAC;  16'h00BD: g = 8'hAB;  16'h00BF: g = 8'hA8;
        16'h00C4: g = 8'h8E;  16'h00C5: g = 8'h8F;  16'h00C6: g = 8'h92;
        16'h00C7: g = 8'h80;  16'h00C9: g = 8'h90;  16'h00D1: g = 8'hA5;
        16'h00D6: g = 8'h99;  16'h00DC: g = 8'h9A;  16'h00DF: g = 8'hE1;
        16'h00E0: g = 8'h85;  16'h00E1: g = 8'hA0;  16'h00E2: g = 8'h83;
        16'h00E4: g = 8'h84;  16'h00E5: g = 8'h86;  16'h00E6: g = 8'h91;
        16'h00E7: g = 8'h87;  16'h00E8: g = 8'h8A;  16'h00E9: g = 8'h82;
        16'h00EA: g = 8'h88;  16'h00EB: g = 8'h89;  16'h00EC: g = 8'h8D;
        16'h00ED: g = 8'hA1;  16'h00EE: g = 8'h8C;  16'h00EF: g = 8'h8B;
        16'h00F1: g = 8'hA4;  16'h00F2: g = 8'h95;  16'h00F3: g = 8'hA2;
        16'h00F4: g = 8'h93;  16'h00F6: g = 8'h94;  16'h00F7: g = 8'hF6;
        16'h00F9: g = 8'h97;  16'h00FA: g = 8'hA3;  16'h00FB: g = 8'h96;
        16'h00FC: g = 8'h81;  16'h00FF: g = 8'h98;
        16'h0192: g = 8'h9F;
        16'h0393: g = 8'hE2;  16'h0398: g = 8'hE9;  16'h03A3: g = 8'hE4;
        16'h03A6: g = 8'hE8;  16'h03A9: g = 8'hEA;  16'h03B1: g = 8'hE0;
        16'h03B4: g = 8'hEB;  16'h03C0: g = 8'hE3;  16'h03C3: g = 8'hE5;
        16'h03C4: g = 8'hE7;  16'h03C6: g = 8'hED;
        16'h20A7: g = 8'h9E;
        16'h2219: g = 8'hF9;  16'h221A: g = 8'hFB;  16'h2248: g = 8'hF7;
        16'h2261: g = 8'hF0;  16'h2264: g = 8'hF3;  16'h2265: g = 8'hF2;
        16'h2500: g = 8'hC4;  16'h2502: g = 8'hB3;  16'h250C: g = 8'hDA;
        16'h2510: g = 8'hBF;  16'h2514: g = 8'hC0;  16'h2518: g = 8'hD9;
        16'h251C: g = 8'hC3;  16'h2524: g = 8'hB4;  16'h252C: g = 8'hC2;
        16'h2534: g = 8'hC1;  16'h253C: g = 8'hC5;
        16'h2550: g = 8'hCD;  16'h2551: g = 8'hBA;  16'h2554: g = 8'hC9;
        16'h2557: g = 8'hBB;  16'h255A: g = 8'hC8;  16'h255D: g = 8'hBC;
        16'h2580: g = 8'hDF;  16'h2584: g = 8'hDC;  16'h2588: g = 8'hDB;
        16'h258C: g = 8'hDD;  16'h2590: g = 8'hDE;  16'h2591: g = 8'hB0;
        16'h2592: g = 8'hB1;  16'h2593: g = 8'hB2;
        16'h25A0: g = 8'hFE;
        default:  g = UNMAPPED;
      endcase
    end
    return g;
  endfunction

endpackage

FILE: hdl/u2c_stream_if.sv
// ----------------------------------------------------------------------------
// UTF-8 to CP437 stream interfaces
// Valid/ready channels for UTF-8 input bytes and CP437 result bytes.
// ----------------------------------------------------------------------------
interface u2c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

FILE: hdl/u2c_in_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 to CP437 input stage
// Registers one accepted UTF-8 byte until the decoder consumes it.
// ----------------------------------------------------------------------------
module u2c_in_stage import u2c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       go,
  input  logic [7:0] byte_in,
  output logic       valid,
  output logic [7:0] byte_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (go) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_q <= byte_in;
    end
  end

endmodule

FILE: hdl/u2c_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 to CP437 decoder
// Sequence state, code point assembly and glyph lookup for one byte.
// ----------------------------------------------------------------------------
module u2c_decode import u2c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  output dec_res_t   res
);

  pend_t       pend;
  pend_t       pend_next;
  logic [15:0] partial;
  logic [15:0] partial_next;
  logic [15:0] point;

  always_comb begin
    pend_next    = pend;
    partial_next = partial;
    point        = partial | {10'b0, byte_in[5:0]};
    res          = '{emit: 1'b0, glyph: UNMAPPED};
    case (pend)
      PEND_ONE, PEND_TWO: begin
        if (byte_in == END_OF_TEXT) begin
          // drop the cut-off sequence
          pend_next    = PEND_NONE;
          partial_next = '0;
          res          = '{emit: 1'b1, glyph: UNMAPPED};
        end else if (pend == PEND_TWO) begin
          pend_next    = PEND_ONE;
          partial_next = partial | {4'b0, byte_in[5:0], 6'b0};
        end else begin
          pend_next    = PEND_NONE;
          partial_next = '0;
          res          = '{emit: 1'b1, glyph: map_point(point)};
        end
      end
      default: begin
        pend_next = PEND_NONE;
        if (byte_in == END_OF_TEXT) begin
          res = '{emit: 1'b0, glyph: UNMAPPED};
        end else if (!byte_in[7]) begin
          res = '{emit: 1'b1, glyph: byte_in};
        end else if (byte_in[7:5] == LEAD2_TAG) begin
          pend_next    = PEND_ONE;
          partial_next = {5'b0, byte_in[4:0], 6'b0};
        end else if (byte_in[7:4] == LEAD3_TAG) begin
          pend_next    = PEND_TWO;
          partial_next = {byte_in[3:0], 12'b0};
        end else begin
          partial_next = '0;
          res          = '{emit: 1'b1, glyph: UNMAPPED};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= PEND_NONE;
      partial <= '0;
    end else if (step) begin
      pend    <= pend_next;
      partial <= partial_next;
    end
  end

endmodule

FILE: hdl/u2c_out_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 to CP437 result stage
// Holds one CP437 result byte until the receiver takes it.
// ----------------------------------------------------------------------------
module u2c_out_stage import u2c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] glyph_in,
  input  logic       ready,
  output logic       valid,
  output logic [7:0] glyph_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph_q <= glyph_in;
    end
  end

endmodule

FILE: hdl/utf8_to_cp437_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to CP437 transcoder
// Converts a UTF-8 byte stream into code page 437 bytes.
// ----------------------------------------------------------------------------
// Channels: utf8 carries one UTF-8 byte per transfer (zero ends the text),
// cp437 carries one code page 437 byte per transfer.
// Each input byte gives zero or one result: ASCII passes through, a two or
// three byte sequence gives one glyph on its last byte, an unknown lead,
// an unmapped code point or a sequence cut by a zero byte gives '?'.
// Path: the byte that completes a result is held in the input register, and
// its result is loaded into the result register once that register is free.
// Throughput: one byte per cycle unless cp437 stalls; the decode and table
// match sit between the input register and the result register.
// Reset: clears both valid flags and the sequence state; utf8.ready is low
// while rst is high.
// Stall: while a result waits, one more byte is taken into the input
// register; further bytes wait until cp437.ready frees the result register.
module utf8_to_cp437_transcoder import u2c_pkg::*; (
  input logic      clk,
  input logic      rst,
  u2c_in_if.sink   utf8,
  u2c_out_if.source cp437
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       go;
  logic       step;
  logic       take;
  dec_res_t   dec;

  assign go         = !cp437.valid || cp437.ready;
  assign step       = s1_valid && go;
  assign utf8.ready = !rst && (!s1_valid || go);
  assign take       = utf8.valid && utf8.ready;

  u2c_in_stage in_stage (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .go      (go),
    .byte_in (utf8.in_byte),
    .valid   (s1_valid),
    .byte_q  (s1_byte)
  );

  u2c_decode decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (s1_byte),
    .res     (dec)
  );

  u2c_out_stage out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (step && dec.emit),
    .glyph_in (dec.glyph),
    .ready    (cp437.ready),
    .valid    (cp437.valid),
    .glyph_q  (cp437.out_byte)
  );

endmodule

FILE: hdl/u2c_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to CP437 port checker
// Port-level checks on the transcoder, attached by bind.
// ----------------------------------------------------------------------------
`include "utf8_to_cp437_transcoder_macros.svh"

module u2c_checker (
  input logic       clk,
  input logic       rst,
  input logic       utf8_valid,
  input logic       utf8_ready,
  input logic       cp437_valid,
  input logic       cp437_ready,
  input logic [7:0] cp437_out_byte
);

  `U2C_ASSERT(a_hold_stalled, clk, rst, cp437_valid && !cp437_ready |=> cp437_valid && $stable(cp437_out_byte), "stalled result changed")
  `U2C_ASSERT(a_rise_after_transfer, clk, rst, $rose(cp437_valid) |-> $past(utf8_valid && utf8_ready, 2), "result without input transfer")
  `U2C_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !cp437_valid, "result valid after reset")
  `U2C_ASSERT_ALWAYS(a_no_take_in_reset, clk, rst |-> !utf8_ready, "input ready during reset")

endmodule

bind utf8_to_cp437_transcoder u2c_checker checker_inst (
  .clk            (clk),
  .rst            (rst),
  .utf8_valid     (utf8.valid),
  .utf8_ready     (utf8.ready),
  .cp437_valid    (cp437.valid),
  .cp437_ready    (cp437.ready),
  .cp437_out_byte (cp437.out_byte)
);

FILE: tb/sv/utf8_to_cp437_transcoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to CP437 transcoder testbench
// Streams directed and random UTF-8 text through the block with random gaps
// and back-pressure, predicts each CP437 byte with its own decoder and glyph
// table, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module utf8_to_cp437_transcoder_tb;
  import u2c_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TEXT_ITEMS  = 1100;
  localparam int unsigned N_PAIRS     = 98;

  // {code point, glyph}
  localparam logic [23:0] CP437_PAIRS [N_PAIRS] = '{
    24'h00A0FF, 24'h00A1AD, 24'h00A29B, 24'h00A39C, 24'h00A59D, 24'h00AAA6,
    24'h00ABAE, 24'h00ACAA, 24'h00B0F8, 24'h00B1F1, 24'h00B2FD, 24'h00B5E6,
    24'h00B7FA, 24'h00BAA7, 24'h00BBAF, 24'h00BCAC, 24'h00BDAB, 24'h00BFA8,
    24'h00C48E, 24'h00C58F, 24'h00C692, 24'h00C780, 24'h00C990, 24'h00D1A5,
    24'h00D699, 24'h00DC9A, 24'h00DFE1, 24'h00E085, 24'h00E1A0, 24'h00E283,
    24'h00E484, 24'h00E586, 24'h00E691, 24'h00E787, 24'h00E88A, 24'h00E982,
    24'h00EA88, 24'h00EB89, 24'h00EC8D, 24'h00EDA1, 24'h00EE8C, 24'h00EF8B,
    24'h00F1A4, 24'h00F295, 24'h00F3A2, 24'h00F493, 24'h00F694, 24'h00F7F6,
    24'h00F997, 24'h00FAA3, 24'h00FB96, 24'h00FC81, 24'h00FF98, 24'h01929F,
    24'h0393E2, 24'h0398E9, 24'h03A3E4, 24'h03A6E8, 24'h03A9EA, 24'h03B1E0,
    24'h03B4EB, 24'h03C0E3, 24'h03C3E5, 24'h03C4E7, 24'h03C6ED, 24'h20A79E,
    24'h2219F9, 24'h221AFB, 24'h2248F7, 24'h2261F0, 24'h2264F3, 24'h2265F2,
    24'h2500C4, 24'h2502B3, 24'h250CDA, 24'h2510BF, 24'h2514C0, 24'h2518D9,
    24'h251CC3, 24'h2524B4, 24'h252CC2, 24'h2534C1, 24'h253CC5, 24'h2550CD,
    24'h2551BA, 24'h2554C9, 24'h2557BB, 24'h255AC8, 24'h255DBC, 24'h2580DF,
    24'h2584DC, 24'h2588DB, 24'h258CDD, 24'h2590DE, 24'h2591B0, 24'h2592B1,
    24'h2593B2, 24'h25A0FE
  };

  typedef struct {
    logic [7:0]  value;
    int unsigned gap;
    bit          drain;
  } text_item_t;

  logic clk;
  logic rst;

  u2c_in_if  utf8_bus ();
  u2c_out_if cp437_bus ();

  utf8_to_cp437_transcoder uut (
    .clk   (clk),
    .rst   (rst),
    .utf8  (utf8_bus),
    .cp437 (cp437_bus)
  );

  text_item_t  text_queue [$];
  logic [7:0]  glyph_queue [$];
  pend_t       pend_state;
  logic [15:0] partial_point;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned result_count;
  int unsigned in_calm_left;
  int unsigned out_calm_left;
  bit          drain_next;
  bit          byte_taken;
  bit          result_taken;
  bit          item_loaded;
  bit          presenting;
  text_item_t  cur_item;
  int unsigned gap_left;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    utf8_bus.valid = 1'b0;
    utf8_bus.in_byte = 8'h00;
    cp437_bus.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic logic [7:0] cp437_glyph(input logic [15:0] pt);
    logic [7:0] glyph;
    glyph = UNMAPPED;
    if (pt <= ASCII_MAX) begin
      glyph = pt[7:0];
    end else begin
      foreach (CP437_PAIRS[i]) begin
        if (CP437_PAIRS[i][23:8] == pt) glyph = CP437_PAIRS[i][7:0];
      end
    end
    return glyph;
  endfunction

  task automatic expect_glyph(input logic [7:0] glyph);
    glyph_queue = {glyph_queue, glyph};
  endtask

  task automatic transcode_byte(input logic [7:0] b);
    case (pend_state)
      PEND_ONE, PEND_TWO: begin
        if (b == END_OF_TEXT) begin
          expect_glyph(UNMAPPED);
          pend_state = PEND_NONE;
          partial_point = '0;
        end else if (pend_state == PEND_TWO) begin
          partial_point = partial_point | {4'h0, b[5:0], 6'h00};
          pend_state = PEND_ONE;
        end else begin
          expect_glyph(cp437_glyph(partial_point | {10'h000, b[5:0]}));
          pend_state = PEND_NONE;
          partial_point = '0;
        end
      end
      default: begin
        pend_state = PEND_NONE;
        if (b == END_OF_TEXT) begin
          // end of text while idle: nothing to give
        end else if (b < 8'h80) begin
          expect_glyph(b);
        end else if (b[7:5] == LEAD2_TAG) begin
          partial_point = {5'h00, b[4:0], 6'h00};
          pend_state = PEND_ONE;
        end else if (b[7:4] == LEAD3_TAG) begin
          partial_point = {b[3:0], 12'h000};
          pend_state = PEND_TWO;
        end else begin
          partial_point = '0;
          expect_glyph(UNMAPPED);
        end
      end
    endcase
  endtask

  function automatic int unsigned draw_wait(ref int unsigned calm_left);
    int unsigned cycles;
    if (calm_left > 0) begin
      calm_left--;
      cycles = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(20, 60);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 13);
    end
    return cycles;
  endfunction

  task automatic queue_byte(input logic [7:0] value);
    text_item_t item;
    item.value = value;
    item.gap = draw_wait(in_calm_left);
    item.drain = drain_next;
    drain_next = 1'b0;
    text_queue = {text_queue, item};
  endtask

  task automatic queue_point(input logic [15:0] pt);
    if (pt < 16'h0800) begin
      queue_byte({LEAD2_TAG, pt[10:6]});
      queue_byte({2'b10, pt[5:0]});
    end else begin
      queue_byte({LEAD3_TAG, pt[15:12]});
      queue_byte({2'b10, pt[11:6]});
      queue_byte({2'b10, pt[5:0]});
    end
  endtask

  // transfer monitor and checker
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, glyph_queue.size());
      $display("CHECK FAILED");
      $finish;
    end else if (!rst) begin
      if (utf8_bus.valid && utf8_bus.ready) begin
        transcode_byte(utf8_bus.in_byte);
        byte_taken = 1'b1;
      end
      if (cp437_bus.valid && cp437_bus.ready) begin
        result_taken = 1'b1;
        result_count++;
        if (glyph_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected cp437 byte 0x%02h", cp437_bus.out_byte));
        end else begin
          logic [7:0] want;
          want = glyph_queue.pop_front();
          if (cp437_bus.out_byte !== want)
            report_mismatch($sformatf("result %0d out_byte 0x%02h, expected 0x%02h",
                                      result_count, cp437_bus.out_byte, want));
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    logic next_valid;
    next_valid = 1'b0;
    if (rst) begin
      utf8_bus.valid <= 1'b0;
      utf8_bus.in_byte <= 8'h00;
    end else begin
      if (presenting && byte_taken) presenting = 1'b0;
      byte_taken = 1'b0;
      if (presenting) begin
        next_valid = 1'b1;
      end else begin
        if (!item_loaded && text_queue.size() > 0) begin
          cur_item = text_queue.pop_front();
          gap_left = cur_item.gap;
          item_loaded = 1'b1;
        end
        if (item_loaded) begin
          if (cur_item.drain && glyph_queue.size() > 0) begin
            // hold until every pending result is out
          end else if (gap_left > 0) begin
            gap_left--;
          end else begin
            cur_item.drain = 1'b0;
            item_loaded = 1'b0;
            presenting = 1'b1;
            next_valid = 1'b1;
            utf8_bus.in_byte <= cur_item.value;
          end
        end
      end
      utf8_bus.valid <= next_valid;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      cp437_bus.ready <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        stall_left = draw_wait(out_calm_left);
      end
      if (stall_left > 0) begin
        stall_left--;
        cp437_bus.ready <= 1'b0;
      end else begin
        cp437_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned n_conts;
    pend_state = PEND_NONE;
    partial_point = '0;
    error_count = 0;
    cycle_count = 0;
    result_count = 0;
    in_calm_left = 0;
    out_calm_left = 0;
    drain_next = 1'b0;
    byte_taken = 1'b0;
    result_taken = 1'b0;
    item_loaded = 1'b0;
    presenting = 1'b0;
    gap_left = 0;
    stall_left = 0;

    // directed text
    queue_byte(END_OF_TEXT);
    queue_byte(8'h01);
    queue_byte(8'h7F);
    queue_point(16'h00A0);
    queue_point(16'h25A0);
    queue_byte(8'hC0); queue_byte(8'h80);
    queue_byte(8'hC1); queue_byte(8'hBF);
    queue_byte(8'h80);
    queue_byte(8'hFF);
    queue_byte(8'hC3); queue_byte(END_OF_TEXT);
    queue_byte(8'hE2); queue_byte(8'h94); queue_byte(END_OF_TEXT);
    queue_byte(8'hC3); queue_byte(8'h41);
    queue_point(16'h20A7);
    queue_point(16'h00C0);
    queue_point(16'hFFFF);
    drain_next = 1'b1;

    // random text, mostly well formed
    while (text_queue.size() < TEXT_ITEMS) begin
      if (text_queue.size() % 400 < 3 && text_queue.size() > 100) drain_next = 1'b1;
      k = $urandom_range(0, 99);
      if (k < 35) begin
        queue_byte(8'($urandom_range(1, 127)));
      end else if (k < 60) begin
        queue_point(CP437_PAIRS[$urandom_range(0, N_PAIRS - 1)][23:8]);
      end else if (k < 70) begin
        if ($urandom_range(0, 1)) begin
          queue_byte(8'($urandom_range(8'hC0, 8'hDF)));
          n_conts = 1;
        end else begin
          queue_byte(8'($urandom_range(8'hE0, 8'hEF)));
          n_conts = 2;
        end
        repeat (n_conts) queue_byte(8'($urandom_range(1, 255)));
      end else if (k < 78) begin
        queue_point(16'($urandom_range(0, 16'hFFFF)));
      end else if (k < 85) begin
        queue_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                           : $urandom_range(8'hF0, 8'hFF)));
      end else if (k < 91) begin
        queue_byte(END_OF_TEXT);
      end else begin
        // sequence cut short by end of text
        if ($urandom_range(0, 1)) begin
          queue_byte(8'($urandom_range(8'hC0, 8'hDF)));
        end else begin
          queue_byte(8'($urandom_range(8'hE0, 8'hEF)));
          if ($urandom_range(0, 1)) queue_byte(8'($urandom_range(1, 255)));
        end
        queue_byte(END_OF_TEXT);
      end
    end

    wait (!rst);
    wait (text_queue.size() == 0 && !item_loaded && !presenting);
    wait (glyph_queue.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
